/* design/lps_pkg.sv */
package lps_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int MAX_STEPS = 8;
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int NUM_MODES = 11;
    localparam logic [15:0] REPEAT_FOREVER = 16'hFFFF;
    localparam logic [3:0] MODE_ON = 4'd0;
    localparam logic [3:0] MODE_OFF = 4'd1;
    localparam logic [4:0] RESULT_CAP = 5'd16;

    // Operation codes of the input item.
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_SET = 1'b1;

    // Result kinds.
    localparam logic KIND_DRIVE = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    // One mode record as kept per slot.
    typedef struct packed {
        logic        en;
        logic [15:0] pin;
        logic        pwm;
        logic        start_lvl;
        logic [3:0]  mode;
        logic        lvl;
    } mode_rec_t;

    // Per-slot counters.
    typedef struct packed {
        logic        pending;
        logic [2:0]  step;
        logic [15:0] tick_count;
        logic [15:0] repeat_count;
    } slot_cnt_t;

    // One result item.
    typedef struct packed {
        logic        kind;
        logic [2:0]  slot;
        logic [15:0] pin;
        logic        pwm;
        logic        state;
        logic        level;
        logic        accepted;
    } result_t;

    // Number of steps of a fixed profile.
    function automatic logic [2:0] prof_nsteps(input logic [3:0] m);
        logic [2:0] n;
        begin
            case (m)
                4'd4, 4'd5, 4'd8, 4'd9, 4'd10: n = 3'd2;
                4'd6:    n = 3'd4;
                4'd7:    n = 3'd6;
                default: n = 3'd1;
            endcase
            return n;
        end
    endfunction

    // Repetition count of a fixed profile.
    function automatic logic [15:0] prof_reps(input logic [3:0] m);
        logic [15:0] r;
        begin
            case (m)
                4'd4:                           r = 16'd2;
                4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10: r = REPEAT_FOREVER;
                default:                        r = 16'd0;
            endcase
            return r;
        end
    endfunction

    // Duration of one step; steps beyond the table read as zero.
    function automatic logic [15:0] prof_dur(input logic [3:0] m, input logic [2:0] st);
        logic [15:0] d;
        begin
            d = 16'd0;
            case (m)
                4'd0: if (st == 3'd0) d = 16'd1;
                4'd2: if (st == 3'd0) d = 16'd2;
                4'd3: if (st == 3'd0) d = 16'd6;
                4'd4: d = (st == 3'd0) ? 16'd1 : (st == 3'd1) ? 16'd2 : 16'd0;
                4'd5: d = (st == 3'd0) ? 16'd1 : (st == 3'd1) ? 16'd19 : 16'd0;
                4'd6:
                begin
                    case (st)
                        3'd0, 3'd2: d = 16'd1;
                        3'd1:       d = 16'd2;
                        3'd3:       d = 16'd16;
                        default:    d = 16'd0;
                    endcase
                end
                4'd7:
                begin
                    case (st)
                        3'd0, 3'd2, 3'd4: d = 16'd1;
                        3'd1, 3'd3:       d = 16'd2;
                        3'd5:             d = 16'd13;
                        default:          d = 16'd0;
                    endcase
                end
                4'd8: d = (st < 3'd2) ? 16'd10 : 16'd0;
                4'd9: d = (st < 3'd2) ? 16'd5 : 16'd0;
                4'd10: d = (st < 3'd2) ? 16'd2 : 16'd0;
                default: d = 16'd0;
            endcase
            return d;
        end
    endfunction

endpackage

/* design/lps_out_fifo.sv */
// Result queue between the sequencer and the output channel.
module lps_out_fifo
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  lps_pkg::result_t       push_data,
    input  logic                   push_last,
    output logic                   empty,
    output logic                   valid,
    input  logic                   stall,
    output lps_pkg::result_t       head,
    output logic                   head_last
);

    localparam int DEPTH = 32;

    lps_pkg::result_t mem_reg [DEPTH];
    logic             lst_reg [DEPTH];
    logic [4:0]       wr_reg;
    logic [4:0]       rd_reg;
    logic [5:0]       cnt_reg;
    logic             pop;

    assign pop = valid && !stall;
    assign valid = (cnt_reg != 6'd0);
    assign empty = !valid;
    assign head = mem_reg[rd_reg];
    assign head_last = lst_reg[rd_reg];

    // Storage writes.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
            lst_reg[wr_reg] <= push_last;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 5'd1;
            if (pop)
                rd_reg <= rd_reg + 5'd1;
            cnt_reg <= cnt_reg + {5'd0, push} - {5'd0, pop};
        end
    end

endmodule

/* design/led_pattern_sequencer.sv */
// LED pattern sequencer. A set-mode request (func=1) gives exactly one reply. After it is
// taken, the slots are compared one per cycle until the first one that drives the pin, or to the last.
// The request is then resolved and its reply staged, and the reply is queued with last
// set as the sequencer returns to idle. A tick (func=0) walks the slots one per cycle
// through one shared update unit. A slot that gives two drive events holds the walk
// while its events go out one at a time. The walk then ends and the final result, if any,
// is queued with last set. Each result waits in a staging register until the next one
// arrives, so that the final one can carry last. A tick gives up to sixteen results, or
// none at all. A new request is taken only once the sequencer is idle and the result
// queue has drained; the queue gives one result per cycle while the receiver does not
// stall. All slot state lives in registers that reset clears.
module led_pattern_sequencer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [15:0] pin,
    input  logic        driver_pwm,
    input  logic [3:0]  req_mode,
    input  logic        polarity,
    input  logic        keep_last,
    input  logic        pin_read_level,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [2:0]  slot,
    output logic [15:0] pin_out,
    output logic        pwm_drive,
    output logic        drive_state,
    output logic        gpio_level,
    output logic        accepted,
    output logic        last
);

    localparam int SW = lps_pkg::SLOT_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SET, ST_TICK, ST_DONE} state_t;

    state_t                 state_reg;
    lps_pkg::mode_rec_t     act_reg [lps_pkg::NUM_SLOTS];
    lps_pkg::mode_rec_t     bak_reg [lps_pkg::NUM_SLOTS];
    lps_pkg::mode_rec_t     shd_reg [lps_pkg::NUM_SLOTS];
    lps_pkg::slot_cnt_t     cnt_reg [lps_pkg::NUM_SLOTS];
    logic [SW:0]            idx_reg;
    logic [4:0]             nres_reg;
    logic                   found_reg;
    logic [SW-1:0]          fslot_reg;
    logic                   free_reg;
    logic [SW-1:0]          free_idx_reg;
    logic                   half_reg;
    logic [15:0]            q_pin_reg;
    logic                   q_pwm_reg;
    logic [3:0]             q_mode_reg;
    logic                   q_pol_reg;
    logic                   q_keep_reg;
    logic                   q_rd_reg;

    logic                   fifo_empty;
    logic                   push;
    logic                   push_last;
    lps_pkg::result_t       push_data;
    lps_pkg::result_t       head;
    logic                   head_last;
    lps_pkg::result_t       pend_reg;
    logic                   pend_valid_reg;

    logic [SW-1:0]          cur;
    lps_pkg::mode_rec_t     a_cur;
    lps_pkg::slot_cnt_t     c_cur;
    lps_pkg::mode_rec_t     a_new;
    lps_pkg::mode_rec_t     b_new;
    lps_pkg::mode_rec_t     s_new;
    lps_pkg::slot_cnt_t     c_new;
    logic                   ev_pend;
    logic                   ev_main;
    logic [1:0]             ev_n;
    lps_pkg::result_t       ev0;
    lps_pkg::result_t       ev1;
    lps_pkg::result_t       ev_first;
    logic [3:0]             m;
    logic [15:0]            dur;
    logic [15:0]            tc;
    logic [2:0]             nst;
    logic [2:0]             stp;
    logic                   ph;

    logic                   tick_emit;
    logic                   tick_split;
    lps_pkg::result_t       tick_data;

    logic                   set_ok;
    logic                   set_chg;
    logic                   set_hit;
    logic [SW-1:0]          set_slot;
    lps_pkg::mode_rec_t     set_rec;
    lps_pkg::result_t       set_reply;

    assign in_stall = (state_reg != ST_IDLE) || !fifo_empty || pend_valid_reg;
    assign cur = idx_reg[SW-1:0];
    assign a_cur = act_reg[cur];
    assign c_cur = cnt_reg[cur];

    // Drive event builder.
    function automatic lps_pkg::result_t mk_drive(input logic [SW-1:0] s,
                                                  input lps_pkg::mode_rec_t a,
                                                  input logic st);
        lps_pkg::result_t r;
        begin
            r.kind = lps_pkg::KIND_DRIVE;
            r.slot = 3'(s);
            r.pin = a.pin;
            r.pwm = a.pwm;
            r.state = st;
            r.level = a.pwm ? 1'b0 : (a.lvl ? st : !st);
            r.accepted = 1'b0;
            return r;
        end
    endfunction

    // Shared per-slot tick update unit.
    always_comb
    begin
        a_new = a_cur;
        b_new = bak_reg[cur];
        s_new = shd_reg[cur];
        c_new = c_cur;
        ev_pend = 1'b0;
        ev_main = 1'b0;
        ev0 = '0;
        ev1 = '0;
        m = '0;
        dur = '0;
        tc = '0;
        nst = '0;
        stp = '0;
        ph = 1'b0;
        if (c_cur.pending || a_cur.en)
        begin
            if (c_cur.pending)
            begin
                a_new = shd_reg[cur];
                c_new = '0;
                s_new.en = 1'b0;
                if (a_new.mode >= 4'd2)
                begin
                    ev0 = mk_drive(cur, a_new, 1'b1);
                    ev_pend = 1'b1;
                end
            end
            m = (a_new.mode >= 4'(lps_pkg::NUM_MODES)) ? lps_pkg::MODE_OFF : a_new.mode;
            if (m == lps_pkg::MODE_ON)
            begin
                ev1 = mk_drive(cur, a_new, 1'b1);
                ev_main = 1'b1;
            end
            else if (m == lps_pkg::MODE_OFF)
            begin
                ev1 = mk_drive(cur, a_new, 1'b0);
                ev_main = 1'b1;
                if (b_new.en)
                begin
                    a_new = b_new;
                    b_new = '0;
                    c_new.repeat_count = '0;
                    c_new.tick_count = '0;
                end
                else
                    a_new.en = 1'b0;
            end
            else
            begin
                dur = lps_pkg::prof_dur(m, c_new.step);
                nst = lps_pkg::prof_nsteps(m);
                tc = (c_new.tick_count != 16'hFFFF) ? c_new.tick_count + 16'd1
                                                    : c_new.tick_count;
                c_new.tick_count = tc;
                if (tc >= dur)
                begin
                    if (nst == 3'd1)
                    begin
                        ev1 = mk_drive(cur, a_new, 1'b0);
                        ev_main = 1'b1;
                        if (b_new.en)
                        begin
                            a_new = b_new;
                            b_new = '0;
                            c_new.repeat_count = '0;
                        end
                        else
                            a_new.en = 1'b0;
                        c_new.tick_count = dur;
                    end
                    else if (lps_pkg::prof_reps(m) == lps_pkg::REPEAT_FOREVER ||
                             c_new.repeat_count < lps_pkg::prof_reps(m))
                    begin
                        c_new.tick_count = '0;
                        stp = c_new.step + 3'd1;
                        if (stp >= nst)
                        begin
                            c_new.repeat_count = c_new.repeat_count + 16'd1;
                            stp = 3'd0;
                        end
                        c_new.step = stp;
                        ph = !stp[0];
                        ev1 = mk_drive(cur, a_new, a_new.lvl ? ph : !ph);
                        ev_main = 1'b1;
                    end
                    else if (c_new.repeat_count == lps_pkg::prof_reps(m))
                    begin
                        ev1 = mk_drive(cur, a_new, a_new.start_lvl);
                        ev_main = 1'b1;
                        if (b_new.en)
                        begin
                            a_new = b_new;
                            b_new = '0;
                            c_new.repeat_count = '0;
                            c_new.tick_count = '0;
                        end
                        else
                            a_new.en = 1'b0;
                    end
                end
            end
        end
        // The load event, when there is one, goes out before the step event.
        ev_n = {1'b0, ev_pend} + {1'b0, ev_main};
        ev_first = ev_pend ? ev0 : ev1;
    end

    // Event selection during the walk; a two-event slot sends its events one at a time.
    always_comb
    begin
        tick_emit = 1'b0;
        tick_split = 1'b0;
        tick_data = ev_first;
        if (state_reg == ST_TICK && idx_reg < (SW+1)'(lps_pkg::NUM_SLOTS) &&
            nres_reg < lps_pkg::RESULT_CAP)
        begin
            if (ev_n == 2'd2 && !half_reg)
            begin
                tick_emit = 1'b1;
                tick_split = 1'b1;
            end
            else if (ev_n != 2'd0)
            begin
                tick_emit = 1'b1;
                tick_data = (ev_n == 2'd2) ? ev1 : ev_first;
            end
        end
    end

    // Set-mode resolution once the slot search has ended.
    always_comb
    begin
        set_ok = (q_mode_reg < 4'(lps_pkg::NUM_MODES));
        set_chg = (q_mode_reg != act_reg[fslot_reg].mode) ||
                  (lps_pkg::prof_nsteps(q_mode_reg) == 3'd1);
        set_slot = found_reg ? fslot_reg : free_idx_reg;
        if (found_reg)
            set_hit = set_ok && !(set_chg && (cnt_reg[fslot_reg].pending ||
                                              act_reg[fslot_reg].pwm != q_pwm_reg));
        else
            set_hit = set_ok && free_reg;
        set_rec = shd_reg[set_slot];
        if (!found_reg)
            set_rec.start_lvl = q_pwm_reg ? 1'b0 : q_rd_reg;
        else if (set_chg)
            set_rec.start_lvl = act_reg[fslot_reg].start_lvl;
        set_rec.mode = q_mode_reg;
        set_rec.pwm = q_pwm_reg;
        set_rec.pin = q_pin_reg;
        set_rec.lvl = q_pol_reg;
        set_rec.en = 1'b1;
        set_reply = '0;
        set_reply.kind = lps_pkg::KIND_REPLY;
        set_reply.pin = q_pin_reg;
        set_reply.accepted = set_hit;
        if (set_ok && (found_reg || free_reg))
            set_reply.slot = 3'(set_slot);
    end

    // Result push: a staged result goes into the queue when the next one arrives,
    // and the final one goes in with last set when the request is done.
    always_comb
    begin
        push = 1'b0;
        push_data = pend_reg;
        push_last = 1'b0;
        if (state_reg == ST_DONE)
        begin
            push = pend_valid_reg;
            push_last = 1'b1;
        end
        else if (tick_emit)
            push = pend_valid_reg;
    end

    lps_out_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .push_last (push_last),
        .empty     (fifo_empty),
        .valid     (out_valid),
        .stall     (out_stall),
        .head      (head),
        .head_last (head_last)
    );

    assign kind = head.kind;
    assign slot = head.slot;
    assign pin_out = head.pin;
    assign pwm_drive = head.pwm;
    assign drive_state = head.state;
    assign gpio_level = head.level;
    assign accepted = head.accepted;
    assign last = head_last;

    // Sequencer and slot state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg <= '0;
            nres_reg <= '0;
            pend_valid_reg <= 1'b0;
            pend_reg <= '0;
            found_reg <= 1'b0;
            fslot_reg <= '0;
            free_reg <= 1'b0;
            free_idx_reg <= '0;
            half_reg <= 1'b0;
            q_pin_reg <= '0;
            q_pwm_reg <= 1'b0;
            q_mode_reg <= '0;
            q_pol_reg <= 1'b0;
            q_keep_reg <= 1'b0;
            q_rd_reg <= 1'b0;
            for (int i = 0; i < lps_pkg::NUM_SLOTS; i++)
            begin
                act_reg[i] <= '0;
                bak_reg[i] <= '0;
                shd_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        q_pin_reg <= pin;
                        q_pwm_reg <= driver_pwm;
                        q_mode_reg <= req_mode;
                        q_pol_reg <= polarity;
                        q_keep_reg <= keep_last;
                        q_rd_reg <= pin_read_level;
                        idx_reg <= '0;
                        nres_reg <= '0;
                        found_reg <= 1'b0;
                        free_reg <= 1'b0;
                        half_reg <= 1'b0;
                        state_reg <= (func == lps_pkg::FUNC_SET) ? ST_SET : ST_TICK;
                    end
                end
                ST_SET:
                begin
                    // One slot compared per cycle; the first match or the last free
                    // slot wins.
                    if (idx_reg < (SW+1)'(lps_pkg::NUM_SLOTS) && !found_reg)
                    begin
                        if (a_cur.en && a_cur.pin == q_pin_reg)
                        begin
                            found_reg <= 1'b1;
                            fslot_reg <= cur;
                        end
                        else if (!a_cur.en && !shd_reg[cur].en)
                        begin
                            free_reg <= 1'b1;
                            free_idx_reg <= cur;
                        end
                        idx_reg <= idx_reg + (SW+1)'(1);
                    end
                    else
                    begin
                        pend_valid_reg <= 1'b1;
                        pend_reg <= set_reply;
                        state_reg <= ST_DONE;
                        if (set_ok && found_reg && q_keep_reg)
                            bak_reg[fslot_reg] <= act_reg[fslot_reg];
                        if (set_hit)
                        begin
                            shd_reg[set_slot] <= set_rec;
                            cnt_reg[set_slot].pending <= 1'b1;
                        end
                    end
                end
                ST_TICK:
                begin
                    // One slot through the update unit each cycle; events go out
                    // one per cycle, so a two-event slot holds the walk until its second event goes out.
                    if (idx_reg < (SW+1)'(lps_pkg::NUM_SLOTS))
                    begin
                        if (tick_split)
                            half_reg <= 1'b1;
                        else
                        begin
                            act_reg[cur] <= a_new;
                            bak_reg[cur] <= b_new;
                            shd_reg[cur] <= s_new;
                            cnt_reg[cur] <= c_new;
                            half_reg <= 1'b0;
                            idx_reg <= idx_reg + (SW+1)'(1);
                        end
                        if (tick_emit)
                        begin
                            pend_valid_reg <= 1'b1;
                            pend_reg <= tick_data;
                            nres_reg <= nres_reg + 5'd1;
                        end
                    end
                    else
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    pend_valid_reg <= 1'b0;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != ST_IDLE))
        else $error("request accepted but sequencer stayed idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input open while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (nres_reg <= lps_pkg::RESULT_CAP))
        else $error("result count beyond cap");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(pin_out) && $stable(kind)))
        else $error("stalled result changed");

endmodule

/* bench/led_pattern_sequencer_tb.sv */
module led_pattern_sequencer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        func;
    logic [15:0] pin;
    logic        driver_pwm;
    logic [3:0]  req_mode;
    logic        polarity;
    logic        keep_last;
    logic        pin_read_level;
    logic        out_valid;
    logic        out_stall;
    logic        kind;
    logic [2:0]  slot;
    logic [15:0] pin_out;
    logic        pwm_drive;
    logic        drive_state;
    logic        gpio_level;
    logic        accepted;
    logic        last;

    // One predicted result together with its end-of-request flag.
    typedef struct packed {
        lps_pkg::result_t res;
        logic             fin;
    } event_exp_t;

    event_exp_t  event_q[$];
    int          error_count;
    int          request_count;
    int          result_count;
    int          idle_cycles;
    bit          stall_enable;
    bit          watchdog_hit;

    // Predictor state.
    lps_pkg::mode_rec_t pr_active [lps_pkg::NUM_SLOTS];
    lps_pkg::mode_rec_t pr_backup [lps_pkg::NUM_SLOTS];
    lps_pkg::mode_rec_t pr_shadow [lps_pkg::NUM_SLOTS];
    logic        pr_pending [lps_pkg::NUM_SLOTS];
    logic [2:0]  pr_step [lps_pkg::NUM_SLOTS];
    logic [15:0] pr_ticks [lps_pkg::NUM_SLOTS];
    logic [15:0] pr_reps [lps_pkg::NUM_SLOTS];
    lps_pkg::result_t pr_out[$];

    led_pattern_sequencer u_dut
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .pin(pin), .driver_pwm(driver_pwm), .req_mode(req_mode),
        .polarity(polarity), .keep_last(keep_last), .pin_read_level(pin_read_level),
        .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .slot(slot),
        .pin_out(pin_out), .pwm_drive(pwm_drive), .drive_state(drive_state),
        .gpio_level(gpio_level), .accepted(accepted), .last(last)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Fixed profile tables.
    function automatic int tbl_steps(input int m);
        case (m)
            4, 5, 8, 9, 10: return 2;
            6: return 4;
            7: return 6;
            default: return 1;
        endcase
    endfunction

    function automatic int tbl_reps(input int m);
        if (m == 4)
            return 2;
        if (m >= 5)
            return 'hFFFF;
        return 0;
    endfunction

    function automatic int tbl_dur(input int m, input int st);
        int t6 [4];
        int t7 [6];
        t6 = '{1, 2, 1, 16};
        t7 = '{1, 2, 1, 2, 1, 13};
        case (m)
            0: return (st == 0) ? 1 : 0;
            2: return (st == 0) ? 2 : 0;
            3: return (st == 0) ? 6 : 0;
            4: return (st == 0) ? 1 : (st == 1) ? 2 : 0;
            5: return (st == 0) ? 1 : (st == 1) ? 19 : 0;
            6: return (st < 4) ? t6[st] : 0;
            7: return (st < 6) ? t7[st] : 0;
            8: return (st < 2) ? 10 : 0;
            9: return (st < 2) ? 5 : 0;
            10: return (st < 2) ? 2 : 0;
            default: return 0;
        endcase
    endfunction

    function automatic lps_pkg::result_t make_reply(input int s, input logic [15:0] p,
                                                    input logic acc);
        lps_pkg::result_t r;
        r = '0;
        r.kind = lps_pkg::KIND_REPLY;
        r.slot = s[2:0];
        r.pin = p;
        r.accepted = acc;
        return r;
    endfunction

    task automatic emit_drive(input int s, input logic st);
        lps_pkg::result_t r;
        r = '0;
        r.kind = lps_pkg::KIND_DRIVE;
        r.slot = s[2:0];
        r.pin = pr_active[s].pin;
        r.pwm = pr_active[s].pwm;
        r.state = st;
        r.level = pr_active[s].pwm ? 1'b0 : (pr_active[s].lvl ? st : !st);
        if (pr_out.size() < 16)
            pr_out.push_back(r);
    endtask

    task automatic end_profile(input int s);
        if (pr_backup[s].en)
        begin
            pr_active[s] = pr_backup[s];
            pr_backup[s] = '0;
            pr_reps[s] = '0;
            pr_ticks[s] = '0;
        end
        else
            pr_active[s].en = 1'b0;
    endtask

    task automatic advance_slot(input int s);
        int m;
        int d;
        logic ph;
        if (pr_pending[s])
        begin
            pr_active[s] = pr_shadow[s];
            pr_step[s] = '0;
            pr_ticks[s] = '0;
            pr_reps[s] = '0;
            pr_shadow[s].en = 1'b0;
            pr_pending[s] = 1'b0;
            if (pr_active[s].mode >= 2)
                emit_drive(s, 1'b1);
        end
        else if (!pr_active[s].en)
            return;
        m = pr_active[s].mode;
        if (m >= lps_pkg::NUM_MODES)
            m = 1;
        if (m == 0)
        begin
            emit_drive(s, 1'b1);
            return;
        end
        if (m == 1)
        begin
            emit_drive(s, 1'b0);
            end_profile(s);
            return;
        end
        d = tbl_dur(m, pr_step[s]);
        if (pr_ticks[s] != 16'hFFFF)
            pr_ticks[s] = pr_ticks[s] + 16'd1;
        if (pr_ticks[s] < d)
            return;
        if (tbl_steps(m) == 1)
        begin
            emit_drive(s, 1'b0);
            end_profile(s);
            pr_ticks[s] = d[15:0];
        end
        else if (tbl_reps(m) == 'hFFFF || pr_reps[s] < tbl_reps(m))
        begin
            pr_ticks[s] = '0;
            pr_step[s] = pr_step[s] + 3'd1;
            if (pr_step[s] >= tbl_steps(m))
            begin
                pr_reps[s] = pr_reps[s] + 16'd1;
                pr_step[s] = '0;
            end
            ph = !pr_step[s][0];
            emit_drive(s, pr_active[s].lvl ? ph : !ph);
        end
        else if (pr_reps[s] == tbl_reps(m))
        begin
            emit_drive(s, pr_active[s].start_lvl);
            end_profile(s);
        end
    endtask

    task automatic apply_set_mode(input logic [15:0] p, input logic pw, input logic [3:0] nm,
                                  input logic lv, input logic keep, input logic rd);
        int s;
        int free_idx;
        bit found;
        free_idx = -1;
        found = 0;
        if (nm >= lps_pkg::NUM_MODES)
        begin
            pr_out.push_back(make_reply(0, p, 1'b0));
            return;
        end
        for (s = 0; s < lps_pkg::NUM_SLOTS; s++)
        begin
            if (pr_active[s].en && pr_active[s].pin == p)
            begin
                found = 1;
                break;
            end
            else if (!pr_active[s].en && !pr_shadow[s].en)
                free_idx = s;
        end
        if (found && keep)
            pr_backup[s] = pr_active[s];
        if (!found)
        begin
            if (free_idx < 0)
            begin
                pr_out.push_back(make_reply(0, p, 1'b0));
                return;
            end
            s = free_idx;
            pr_shadow[s].start_lvl = pw ? 1'b0 : rd;
        end
        else if (nm != pr_active[s].mode || tbl_steps(nm) == 1)
        begin
            if (pr_pending[s] || pr_active[s].pwm != pw)
            begin
                pr_out.push_back(make_reply(s, p, 1'b0));
                return;
            end
            pr_shadow[s].start_lvl = pr_active[s].start_lvl;
        end
        pr_shadow[s].mode = nm;
        pr_shadow[s].pwm = pw;
        pr_shadow[s].pin = p;
        pr_shadow[s].lvl = lv;
        pr_shadow[s].en = 1'b1;
        pr_pending[s] = 1'b1;
        pr_out.push_back(make_reply(s, p, 1'b1));
    endtask

    // Predict the results of one request and queue them.
    task automatic predict_request(input logic f, input logic [15:0] p, input logic pw,
                                   input logic [3:0] nm, input logic lv, input logic keep,
                                   input logic rd);
        event_exp_t e;
        pr_out.delete();
        if (f == lps_pkg::FUNC_SET)
            apply_set_mode(p, pw, nm, lv, keep, rd);
        else
            for (int s = 0; s < lps_pkg::NUM_SLOTS; s++)
                advance_slot(s);
        foreach (pr_out[i])
        begin
            e.res = pr_out[i];
            e.fin = (i == pr_out.size() - 1);
            event_q.push_back(e);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on result %0d: %s got %0h expected %0h",
                 result_count, what, got, want);
        error_count++;
    endtask

    // Send one request, predicting its results at acceptance.
    task automatic send_request(input logic f, input logic [15:0] p, input logic pw,
                                input logic [3:0] nm, input logic lv, input logic keep,
                                input logic rd, input bit gaps);
        int n;
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 16);
            repeat (n) @(negedge clk);
        end
        in_valid = 1'b1;
        func = f;
        pin = p;
        driver_pwm = pw;
        req_mode = nm;
        polarity = lv;
        keep_last = keep;
        pin_read_level = rd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_request(f, p, pw, nm, lv, keep, rd);
        request_count++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic tick(input bit gaps);
        send_request(lps_pkg::FUNC_TICK, 16'($urandom), 1'($urandom), 4'($urandom),
                     1'($urandom), 1'($urandom), 1'($urandom), gaps);
    endtask

    task automatic set_mode_req(input logic [15:0] p, input logic pw, input logic [3:0] nm,
                                input logic lv, input logic keep, input logic rd,
                                input bit gaps);
        send_request(lps_pkg::FUNC_SET, p, pw, nm, lv, keep, rd, gaps);
    endtask

    task automatic wait_drained();
        while (event_q.size() != 0 && !watchdog_hit)
            @(negedge clk);
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        event_exp_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (event_q.size() == 0)
            begin
                $display("unexpected result %0d", result_count);
                error_count++;
            end
            else
            begin
                e = event_q.pop_front();
                if (kind !== e.res.kind) report_mismatch("kind", kind, e.res.kind);
                if (slot !== e.res.slot) report_mismatch("slot", slot, e.res.slot);
                if (pin_out !== e.res.pin) report_mismatch("pin_out", pin_out, e.res.pin);
                if (pwm_drive !== e.res.pwm) report_mismatch("pwm_drive", pwm_drive, e.res.pwm);
                if (drive_state !== e.res.state)
                    report_mismatch("drive_state", drive_state, e.res.state);
                if (gpio_level !== e.res.level)
                    report_mismatch("gpio_level", gpio_level, e.res.level);
                if (accepted !== e.res.accepted)
                    report_mismatch("accepted", accepted, e.res.accepted);
                if (last !== e.fin) report_mismatch("last", last, e.fin);
            end
            result_count++;
        end
    end

    // Receiver stall in random bursts.
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_enable && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 16);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles without any accepted request or result.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !watchdog_hit)
        begin
            watchdog_hit = 1;
            $display("watchdog timeout");
            $display("led_pattern_sequencer_tb NOT OK");
            $finish;
        end
    end

    // Pin extremes, out-of-range modes, every profile, both polarities.
    task automatic test_directed();
        set_mode_req(16'h0000, 1'b0, 4'd0, 1'b1, 1'b0, 1'b1, 1'b1);
        set_mode_req(16'hFFFF, 1'b1, 4'd5, 1'b0, 1'b0, 1'b0, 1'b1);
        set_mode_req(16'h1234, 1'b0, 4'd11, 1'b1, 1'b0, 1'b0, 1'b1);
        set_mode_req(16'h1234, 1'b0, 4'd15, 1'b1, 1'b0, 1'b0, 1'b1);
        tick(1'b0);
        // Mode change on a pending pin and a driver change.
        set_mode_req(16'hFFFF, 1'b1, 4'd7, 1'b1, 1'b0, 1'b0, 1'b1);
        set_mode_req(16'hFFFF, 1'b0, 4'd7, 1'b1, 1'b1, 1'b0, 1'b1);
        set_mode_req(16'hFFFF, 1'b1, 4'd5, 1'b1, 1'b1, 1'b0, 1'b1);
        for (int m = 2; m <= 10; m++)
            set_mode_req(16'(16'h0100 + m), m[0], m[3:0], m[1], 1'b0, m[2], 1'b1);
        // All slots busy: no free slot left.
        set_mode_req(16'h0A0A, 1'b0, 4'd4, 1'b1, 1'b0, 1'b0, 1'b1);
        repeat (4) tick(1'b0);
        wait_drained();
    endtask

    // Random requests on a small pin pool, mostly ticks to run profiles through.
    task automatic test_random(input int count, input bit gaps);
        logic [15:0] p;
        logic [3:0]  nm;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 6)
                tick(gaps);
            else
            begin
                p = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 11));
                nm = ($urandom_range(0, 15) == 0) ? 4'($urandom) : 4'($urandom_range(0, 10));
                set_mode_req(p, 1'($urandom), nm, 1'($urandom), 1'($urandom),
                             1'($urandom), gaps);
            end
        end
    endtask

    // Backup restore: keep_last then a finite profile that finishes.
    task automatic test_backup_restore();
        set_mode_req(16'h0055, 1'b0, 4'd8, 1'b1, 1'b0, 1'b0, 1'b1);
        tick(1'b1);
        set_mode_req(16'h0055, 1'b0, 4'd4, 1'b0, 1'b1, 1'b1, 1'b1);
        repeat (12) tick(1'b1);
        wait_drained();
    endtask

    initial
    begin
        error_count = 0;
        request_count = 0;
        result_count = 0;
        idle_cycles = 0;
        watchdog_hit = 0;
        stall_enable = 1;
        for (int s = 0; s < lps_pkg::NUM_SLOTS; s++)
        begin
            pr_active[s] = '0;
            pr_backup[s] = '0;
            pr_shadow[s] = '0;
            pr_pending[s] = 1'b0;
            pr_step[s] = '0;
            pr_ticks[s] = '0;
            pr_reps[s] = '0;
        end
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = 1'b0;
        pin = '0;
        driver_pwm = 1'b0;
        req_mode = '0;
        polarity = 1'b0;
        keep_last = 1'b0;
        pin_read_level = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_backup_restore();
        test_random(160, 1'b1);
        wait_drained();
        test_random(120, 1'b1);
        // Final stretch at full rate on both sides.
        stall_enable = 0;
        test_random(60, 1'b0);
        wait_drained();
        repeat (40) @(negedge clk);

        $display("covered %0d requests and %0d results over all profiles, with stalls",
                 request_count, result_count);
        if (error_count == 0 && event_q.size() == 0)
            $display("led_pattern_sequencer_tb OK");
        else
        begin
            $display("%0d mismatches, %0d results never arrived", error_count, event_q.size());
            $display("led_pattern_sequencer_tb NOT OK");
        end
        $finish;
    end

endmodule
